FILE: rtl/core/trm_pkg.sv
// Shared types and constants for the register machine execute stage.
// Holds opcode, operand-kind, flag and error codes plus the stream payload layouts.
// No dependencies.
package trm_pkg;

    // Default machine size
    localparam int NUM_REGS_DEF   = 10;
    localparam int MEM_WORDS_DEF  = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the stream payloads
    localparam int ACTION_W    = 4;
    localparam int REG_FIELD_W = 4;
    localparam int KIND_W      = 2;
    localparam int WORD_W      = 32;
    localparam int TARGET_W    = 16;
    localparam int ST_ADDR_W   = 8;
    localparam int ERR_W       = 2;

    localparam int IN_BITS   = ACTION_W + REG_FIELD_W + KIND_W + 3 * WORD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + TARGET_W + 1 + 1 + WORD_W + 1 + ST_ADDR_W + WORD_W + ERR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RET       = 4'd0,
        ACT_ADD       = 4'd1,
        ACT_COMP      = 4'd2,
        ACT_WRITE_REG = 4'd3,
        ACT_GETINT    = 4'd4,
        ACT_JE        = 4'd5,
        ACT_JG        = 4'd6,
        ACT_JL        = 4'd7,
        ACT_JUMP      = 4'd8,
        ACT_LOAD      = 4'd9,
        ACT_MOVE      = 4'd10,
        ACT_PRINT     = 4'd11,
        ACT_MUL       = 4'd12,
        ACT_SUB       = 4'd13,
        ACT_STORE     = 4'd14
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REG   = 2'd0,
        KIND_CONST = 2'd1,
        KIND_MEM   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_GT   = 2'd1,
        FLAG_EQ   = 2'd2,
        FLAG_LT   = 2'd3
    } flag_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_FORM = 2'd1,
        ERR_RANGE    = 2'd2
    } err_t;

    // Input item, action field in the lowest bits
    typedef struct packed {
        logic [IN_TDATA_W-IN_BITS-1:0] pad;
        logic [WORD_W-1:0]             read_value;
        logic [WORD_W-1:0]             mem_data;
        logic [WORD_W-1:0]             src_value;
        logic [KIND_W-1:0]             src_kind;
        logic [REG_FIELD_W-1:0]        dest_reg;
        logic [ACTION_W-1:0]           action;
    } in_item_t;

    // Result item, branch_taken field in the lowest bits
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
        logic [ERR_W-1:0]                error_code;
        logic [WORD_W-1:0]               store_data;
        logic [ST_ADDR_W-1:0]            store_address;
        logic                            store_valid;
        logic [WORD_W-1:0]               out_value;
        logic                            out_valid;
        logic                            halt;
        logic [TARGET_W-1:0]             branch_target;
        logic                            branch_taken;
    } res_item_t;

    // Sign-extend a 32-bit word to 64 bits
    function automatic logic [63:0] sext64(input logic [WORD_W-1:0] v);
        return {{(64 - WORD_W){v[WORD_W-1]}}, v};
    endfunction

endpackage

FILE: rtl/core/toy_register_machine_execute.sv
// Execute stage of a ten-register toy machine: register file, compare flag, ALU.
// Uses trm_pkg for opcodes, codes and payload layouts.
//
// Usage:
//   Slave stream (s_axis_*) carries one decoded instruction per transfer; master
//   stream (m_axis_*) returns exactly one result per instruction, in order.
//   Memory sits outside: the word at the source address comes in with the
//   instruction, and a store leaves as store_valid/store_address/store_data.
//   The accepted instruction is captured into the input register together with
//   both register-file reads (bypassed from the instruction executing in that
//   same cycle). When the output register is free or being read, the ALU result
//   is written back and the result lands in the output register.
//   Throughput: one instruction per cycle while the receiver does not stall; the
//   register-file write-back and the single multiplier sit in the execute step.
//   Receiver stall: the output register holds its result and the input
//   register holds the next instruction; s_axis_tready drops only when both
//   are full, so at most two instructions are in flight.
//   Reset: all registers read as zero and the compare flag is none; the block
//   is ready right after reset.
module toy_register_machine_execute #(
    parameter int NUM_REGS   = trm_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS  = trm_pkg::MEM_WORDS_DEF,
    parameter int DATA_WIDTH = trm_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // action[3:0], dest_reg[7:4], src_kind[9:8], src_value[41:10],
    // mem_data[73:42], read_value[105:74], zero fill
    input  logic [trm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // branch_taken[0], branch_target[16:1], halt[17], out_valid[18],
    // out_value[50:19], store_valid[51], store_address[59:52],
    // store_data[91:60], error_code[93:92], zero fill
    output logic [trm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Handshake and pipeline control
    logic                  s_fire;
    logic                  advance;
    logic                  exec_fire;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  m_valid_reg;

    // Input register
    trm_pkg::in_item_t     in_item;
    trm_pkg::in_item_t     s1_item_reg;
    logic [DATA_WIDTH-1:0] a_raw_reg;
    logic                  a_vld_reg;
    logic [DATA_WIDTH-1:0] b_raw_reg;
    logic                  b_vld_reg;

    // Register file and flag
    logic [DATA_WIDTH-1:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   rf_valid_reg;
    trm_pkg::flag_t        flag_reg;
    trm_pkg::flag_t        flag_next;
    logic                  flag_wr;

    // Write port
    logic                  wr_en;
    logic [RIDX_W-1:0]     wr_idx;
    logic [DATA_WIDTH-1:0] wr_data;

    // Read ports on the incoming instruction
    logic                  in_dst_ok;
    logic                  in_src_ok;
    logic [RIDX_W-1:0]     in_dst_idx;
    logic [RIDX_W-1:0]     in_src_idx;

    // Execute
    trm_pkg::res_item_t    res;
    trm_pkg::res_item_t    m_data_reg;

    assign in_item = trm_pkg::in_item_t'(s_axis_tdata);

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = s1_valid_reg && advance;

    // Hold or advance the input register valid
    always_comb
    begin
        if (s_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
                m_valid_reg <= s1_valid_reg;
        end
    end

    // Decode read addresses of the incoming instruction
    assign in_dst_ok  = {1'b0, in_item.dest_reg} < (trm_pkg::REG_FIELD_W + 1)'(NUM_REGS);
    assign in_src_ok  = in_item.src_value < trm_pkg::WORD_W'(NUM_REGS);
    assign in_dst_idx = in_item.dest_reg[RIDX_W-1:0];
    assign in_src_idx = in_item.src_value[RIDX_W-1:0];

    // Capture the instruction and read both operands, bypassing the write in flight
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_item_reg <= in_item;
            if (wr_en && in_dst_ok && wr_idx == in_dst_idx)
            begin
                a_raw_reg <= wr_data;
                a_vld_reg <= 1'b1;
            end
            else
            begin
                if (in_dst_ok)
                    a_raw_reg <= rf_mem[in_dst_idx];
                a_vld_reg <= in_dst_ok && rf_valid_reg[in_dst_idx];
            end
            if (wr_en && in_src_ok && wr_idx == in_src_idx)
            begin
                b_raw_reg <= wr_data;
                b_vld_reg <= 1'b1;
            end
            else
            begin
                if (in_src_ok)
                    b_raw_reg <= rf_mem[in_src_idx];
                b_vld_reg <= in_src_ok && rf_valid_reg[in_src_idx];
            end
        end
    end

    // Write back to the register file
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rf_mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            flag_reg     <= trm_pkg::FLAG_NONE;
        end
        else
        begin
            if (wr_en)
                rf_valid_reg[wr_idx] <= 1'b1;
            if (flag_wr)
                flag_reg <= flag_next;
        end
    end

    // Execute one instruction
    always_comb
    begin
        logic [DATA_WIDTH-1:0] a_val;
        logic [DATA_WIDTH-1:0] b_val;
        logic [DATA_WIDTH-1:0] opnd;
        logic [DATA_WIDTH-1:0] alu;
        logic [DATA_WIDTH-1:0] k_val;
        logic [DATA_WIDTH-1:0] m_val;
        logic [DATA_WIDTH-1:0] r_val;
        logic [63:0]           a_zext;
        logic                  dst_ok;
        logic                  src_ok;
        logic                  addr_ok;
        logic                  do_wr;
        logic                  taken;
        trm_pkg::err_t         err;
        trm_pkg::action_t      act;
        trm_pkg::kind_t        kind;

        a_val   = a_vld_reg ? a_raw_reg : '0;
        b_val   = b_vld_reg ? b_raw_reg : '0;
        m_val   = '0;
        r_val   = '0;
        a_zext  = 64'(a_val);
        dst_ok  = {1'b0, s1_item_reg.dest_reg} < (trm_pkg::REG_FIELD_W + 1)'(NUM_REGS);
        src_ok  = s1_item_reg.src_value < trm_pkg::WORD_W'(NUM_REGS);
        addr_ok = s1_item_reg.src_value < trm_pkg::WORD_W'(MEM_WORDS);
        act     = trm_pkg::action_t'(s1_item_reg.action);
        kind    = trm_pkg::kind_t'(s1_item_reg.src_kind);
        opnd    = '0;
        alu     = '0;
        do_wr   = 1'b0;
        taken   = 1'b0;
        err     = trm_pkg::ERR_NONE;
        res     = '0;
        wr_data = '0;
        flag_next = flag_reg;
        flag_wr   = 1'b0;

        k_val = DATA_WIDTH'(trm_pkg::sext64(s1_item_reg.src_value));
        m_val = DATA_WIDTH'(trm_pkg::sext64(s1_item_reg.mem_data));
        r_val = DATA_WIDTH'(trm_pkg::sext64(s1_item_reg.read_value));

        // Select the second operand for arithmetic, compare and load
        case (kind)
            trm_pkg::KIND_REG:
            begin
                opnd = b_val;
                if (!src_ok)
                    err = trm_pkg::ERR_BAD_FORM;
            end
            trm_pkg::KIND_CONST:
                opnd = k_val;
            trm_pkg::KIND_MEM:
            begin
                opnd = m_val;
                if (!addr_ok)
                    err = trm_pkg::ERR_RANGE;
            end
            default:
                err = trm_pkg::ERR_BAD_FORM;
        endcase

        unique case (act) inside
            trm_pkg::ACT_RET:
            begin
                err      = trm_pkg::ERR_NONE;
                res.halt = 1'b1;
            end
            trm_pkg::ACT_ADD, trm_pkg::ACT_SUB, trm_pkg::ACT_MUL:
            begin
                if (!dst_ok)
                    err = trm_pkg::ERR_BAD_FORM;
                case (act)
                    trm_pkg::ACT_ADD: alu = a_val + opnd;
                    trm_pkg::ACT_SUB: alu = a_val - opnd;
                    default:          alu = DATA_WIDTH'(a_val * opnd);
                endcase
                wr_data = alu;
                do_wr   = 1'b1;
            end
            trm_pkg::ACT_COMP:
            begin
                if (!dst_ok || kind == trm_pkg::KIND_MEM)
                    err = trm_pkg::ERR_BAD_FORM;
                if ($signed(a_val) > $signed(opnd))
                    flag_next = trm_pkg::FLAG_GT;
                else if (a_val == opnd)
                    flag_next = trm_pkg::FLAG_EQ;
                else
                    flag_next = trm_pkg::FLAG_LT;
                flag_wr = (err == trm_pkg::ERR_NONE) && exec_fire;
            end
            trm_pkg::ACT_WRITE_REG:
            begin
                err = dst_ok ? trm_pkg::ERR_NONE : trm_pkg::ERR_BAD_FORM;
                res.out_valid = 1'b1;
                res.out_value = a_zext[trm_pkg::WORD_W-1:0];
            end
            trm_pkg::ACT_GETINT:
            begin
                err     = dst_ok ? trm_pkg::ERR_NONE : trm_pkg::ERR_BAD_FORM;
                wr_data = r_val;
                do_wr   = 1'b1;
            end
            trm_pkg::ACT_JE, trm_pkg::ACT_JG, trm_pkg::ACT_JL, trm_pkg::ACT_JUMP:
            begin
                err   = trm_pkg::ERR_NONE;
                taken = (act == trm_pkg::ACT_JUMP) ||
                        (act == trm_pkg::ACT_JE && flag_reg == trm_pkg::FLAG_EQ) ||
                        (act == trm_pkg::ACT_JG && flag_reg == trm_pkg::FLAG_GT) ||
                        (act == trm_pkg::ACT_JL && flag_reg == trm_pkg::FLAG_LT);
                res.branch_taken  = taken;
                res.branch_target = taken ?
                    s1_item_reg.src_value[trm_pkg::TARGET_W-1:0] : '0;
            end
            trm_pkg::ACT_LOAD:
            begin
                if (!dst_ok || kind == trm_pkg::KIND_REG)
                    err = trm_pkg::ERR_BAD_FORM;
                wr_data = opnd;
                do_wr   = 1'b1;
            end
            trm_pkg::ACT_MOVE:
            begin
                err = (dst_ok && kind == trm_pkg::KIND_REG && src_ok) ?
                      trm_pkg::ERR_NONE : trm_pkg::ERR_BAD_FORM;
                wr_data = b_val;
                do_wr   = 1'b1;
            end
            trm_pkg::ACT_STORE:
            begin
                if (!dst_ok)
                    err = trm_pkg::ERR_BAD_FORM;
                else if (!addr_ok)
                    err = trm_pkg::ERR_RANGE;
                else
                    err = trm_pkg::ERR_NONE;
                res.store_valid   = 1'b1;
                res.store_address = s1_item_reg.src_value[trm_pkg::ST_ADDR_W-1:0];
                res.store_data    = a_zext[trm_pkg::WORD_W-1:0];
            end
            default:
                err = trm_pkg::ERR_NONE;
        endcase

        // Drop every effect of a failed instruction
        if (err != trm_pkg::ERR_NONE)
            res = '0;
        res.error_code = err;

        wr_en  = do_wr && (err == trm_pkg::ERR_NONE) && exec_fire;
        wr_idx = s1_item_reg.dest_reg[RIDX_W-1:0];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (exec_fire)
            m_data_reg <= res;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = trm_pkg::OUT_TDATA_W'(m_data_reg);

    // A failed instruction leaves no other field set
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg.error_code != trm_pkg::ERR_NONE) |->
        (m_data_reg.halt == 1'b0 && m_data_reg.out_valid == 1'b0 &&
         m_data_reg.store_valid == 1'b0 && m_data_reg.branch_taken == 1'b0))
        else $error("error result carries side fields");

    // At most one kind of effect per result
    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> $onehot0({m_data_reg.halt, m_data_reg.out_valid,
                                  m_data_reg.store_valid, m_data_reg.branch_taken}))
        else $error("result carries more than one effect");

    // A stalled instruction neither writes state nor leaves the input register
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> (!wr_en && !flag_wr) ##1 s1_valid_reg)
        else $error("stalled instruction changed state");

    // An empty output register always lets the next instruction in
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input blocked with free output register");

endmodule
